// ===== rtl/bfa_pkg.sv =====
package bfa_pkg;

   localparam int LEN_W = 25;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;
   localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(1048576);
   localparam logic [3:0] ALIGN_RESET = 4'd8;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;
   localparam int CAP_REGS = 3;

   typedef enum logic [1:0] {
      OP_PROBE   = 2'd0,
      OP_ALLOC   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_UNKNOWN = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_NO_FIT  = 2'd1,
      STS_FULL    = 2'd2,
      STS_IGNORED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_ALIGN = 2'd0,
      REG_CAP0  = 2'd1,
      REG_CAP1  = 2'd2,
      REG_CAP2  = 2'd3
   } reg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_COMPACT,
      S_APPEND,
      S_DONE
   } state_type;

endpackage

// ===== rtl/bfa_req_if.sv =====
interface bfa_req_if #(
   parameter int ADDR_BITS = 24
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            operation;
   logic [1:0]            pool_select;
   logic [24:0]           req_size;
   logic [ADDR_BITS-1:0]  req_offset;
   logic                  is_pooled;

   modport source (
      output valid, operation, pool_select, req_size, req_offset, is_pooled,
      input  ready
   );
   modport sink (
      input  valid, operation, pool_select, req_size, req_offset, is_pooled,
      output ready
   );
endinterface

// ===== rtl/bfa_rsp_if.sv =====
interface bfa_rsp_if #(
   parameter int ADDR_BITS = 24
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [ADDR_BITS-1:0]  grant_offset;
   logic [24:0]           grant_length;

   modport source (
      output valid, status, grant_offset, grant_length,
      input  ready
   );
   modport sink (
      input  valid, status, grant_offset, grant_length,
      output ready
   );
endinterface

// ===== rtl/bfa_ram.sv =====
module bfa_ram #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/best_fit_free_list_allocator.sv =====
// Best-fit free-list allocator for POOLS pools of FREE_ENTRIES free ranges each, held in
// one RAM with a single read and a single write port. Every probe, allocate and pooled
// release on a valid pool reads the pool's list one entry per cycle; probe, a refused
// request and a release that finds its list full end there. An allocate or a release that
// changes the list then rewrites it in list order through the single write port. The input
// is not ready while a request is in work. A capacity write resets its pool at once (no
// clearing pass), and so does reset for every pool.
module best_fit_free_list_allocator import bfa_pkg::*; #(
   parameter int POOLS = 3,
   parameter int FREE_ENTRIES = 32,
   parameter int ADDR_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   bfa_req_if.sink           req_ch,
   bfa_rsp_if.source         rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);
   localparam int IW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
   localparam int CW = $clog2(FREE_ENTRIES + 1);
   localparam int PW = (POOLS > 1) ? $clog2(POOLS) : 1;
   localparam int DEPTH = POOLS * FREE_ENTRIES;
   localparam int AW = $clog2(DEPTH);
   localparam int SW = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 2;
   localparam int EW = ADDR_BITS + LEN_W;
   localparam int CFG_POOLS = (POOLS < CAP_REGS) ? POOLS : CAP_REGS;

   typedef struct packed {
      op_type                op;
      logic [PW-1:0]         pool;
      logic [LEN_W-1:0]      size;
      logic [ADDR_BITS-1:0]  off;
      logic [CW-1:0]         n;
      logic [CW-1:0]         iss;
      logic [CW-1:0]         k;
      logic                  pv;
      logic [IW-1:0]         pidx;
      logic                  pfresh;
      logic                  best_ok;
      logic [IW-1:0]         best_idx;
      logic [LEN_W-1:0]      best_rem;
      logic [LEN_W-1:0]      best_len;
      logic [ADDR_BITS-1:0]  best_start;
      logic                  l_ok;
      logic [IW-1:0]         l_idx;
      logic [ADDR_BITS-1:0]  l_start;
      logic                  r_ok;
      logic [IW-1:0]         r_idx;
      logic [SW-1:0]         r_end;
      logic                  app_en;
      logic [ADDR_BITS-1:0]  app_start;
      logic [LEN_W-1:0]      app_len;
      status_type            sts;
      logic [ADDR_BITS-1:0]  goff;
      logic [LEN_W-1:0]      glen;
   } work_type;

   state_type state_ff, state_in;
   work_type  w_ff, w_in;

   logic [3:0]       align_ff, align_in;
   logic [LEN_W-1:0] cap_ff [POOLS];
   logic [LEN_W-1:0] cap_in [POOLS];
   logic [CW-1:0]    count_ff [POOLS];
   logic [CW-1:0]    count_in [POOLS];
   logic [POOLS-1:0] fresh_ff, fresh_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [ADDR_BITS-1:0]  rsp_goff_ff, rsp_goff_in;
   logic [LEN_W-1:0]      rsp_glen_ff, rsp_glen_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr, pool_base;
   logic [EW-1:0] ram_wdata, ram_rdata;

   logic                  req_fire, csr_wr, pool_ok, imm_done;
   logic [1:0]            csr_idx;
   logic [ADDR_BITS-1:0]  ent_start;
   logic [LEN_W-1:0]      ent_len;
   logic [SW-1:0]         ent_end, hi_req, mask, al_sum, ns, best_end;
   logic [SW-1:0]         lo_m, hi_m, diff_m;
   logic                  issue_left, scan_stop, scan_done, compact_done, go_compact;
   logic                  eff_r, pidx_removed, out_free;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign pool_ok = (32'(req_ch.pool_select) < POOLS);
   assign imm_done = (op_type'(req_ch.operation) == OP_UNKNOWN) || !pool_ok
                     || (op_type'(req_ch.operation) == OP_RELEASE && !req_ch.is_pooled);

   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   assign pool_base = AW'(w_ff.pool) * AW'(FREE_ENTRIES);
   assign ram_raddr = pool_base + AW'(w_ff.iss[IW-1:0]);

   // entry 0 of a freshly reset pool is not in the RAM yet
   assign ent_start = w_ff.pfresh ? '0 : ram_rdata[EW-1:LEN_W];
   assign ent_len   = w_ff.pfresh ? cap_ff[w_ff.pool] : ram_rdata[LEN_W-1:0];
   assign ent_end   = SW'(ent_start) + SW'(ent_len);
   assign hi_req    = SW'(w_ff.off) + SW'(w_ff.size);

   assign mask     = (SW'(1) << align_ff) - SW'(1);
   assign al_sum   = SW'(w_ff.best_start) + SW'(w_ff.size) + mask;
   assign ns       = al_sum & ~mask;
   assign best_end = SW'(w_ff.best_start) + SW'(w_ff.best_len);

   assign eff_r  = w_ff.r_ok && !(w_ff.l_ok && w_ff.r_idx == w_ff.l_idx);
   assign lo_m   = w_ff.l_ok ? SW'(w_ff.l_start) : SW'(w_ff.off);
   assign hi_m   = eff_r ? w_ff.r_end : hi_req;
   assign diff_m = (hi_m >= lo_m) ? hi_m - lo_m : '0;

   assign issue_left   = (w_ff.iss < w_ff.n);
   assign scan_stop    = (w_ff.op == OP_RELEASE) && w_ff.l_ok && w_ff.r_ok;
   assign scan_done    = (state_ff == S_SCAN) && ((!issue_left && !w_ff.pv) || scan_stop);
   assign compact_done = (state_ff == S_COMPACT) && !issue_left && !w_ff.pv;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      case (w_ff.op)
         OP_ALLOC:   go_compact = w_ff.best_ok;
         OP_RELEASE: go_compact = w_ff.l_ok || eff_r
                                  || (w_ff.n < CW'(FREE_ENTRIES));
         default:    go_compact = 1'b0;
      endcase
   end

   always_comb begin
      if (w_ff.op == OP_ALLOC) begin
         pidx_removed = w_ff.best_ok && (w_ff.pidx == w_ff.best_idx);
      end else begin
         pidx_removed = (w_ff.l_ok && w_ff.pidx == w_ff.l_idx)
                        || (w_ff.r_ok && w_ff.pidx == w_ff.r_idx);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = imm_done ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = go_compact ? S_COMPACT : S_DONE;
            end
         end
         S_COMPACT: begin
            if (compact_done) begin
               state_in = S_APPEND;
            end
         end
         S_APPEND: state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath, RAM and result
   always_comb begin
      w_in = w_ff;
      align_in = align_ff;
      cap_in = cap_ff;
      count_in = count_ff;
      fresh_in = fresh_ff;
      ram_re = 1'b0;
      ram_we = 1'b0;
      ram_waddr = pool_base + AW'(w_ff.k[IW-1:0]);
      ram_wdata = {ent_start, ent_len};
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_goff_in = rsp_goff_ff;
      rsp_glen_in = rsp_glen_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               w_in.op = op_type'(req_ch.operation);
               w_in.pool = PW'(req_ch.pool_select);
               w_in.size = req_ch.req_size;
               w_in.off = req_ch.req_offset;
               w_in.n = pool_ok ? count_ff[PW'(req_ch.pool_select)] : '0;
               w_in.iss = '0;
               w_in.k = '0;
               w_in.pv = 1'b0;
               w_in.best_ok = 1'b0;
               w_in.l_ok = 1'b0;
               w_in.r_ok = 1'b0;
               w_in.app_en = 1'b0;
               w_in.goff = '0;
               w_in.glen = '0;
               w_in.sts = STS_OK;
               if (op_type'(req_ch.operation) == OP_UNKNOWN) begin
                  w_in.sts = STS_IGNORED;
               end else if (!pool_ok) begin
                  w_in.sts = (op_type'(req_ch.operation) == OP_RELEASE) ? STS_IGNORED
                                                                        : STS_NO_FIT;
               end else if (op_type'(req_ch.operation) == OP_RELEASE
                            && !req_ch.is_pooled) begin
                  w_in.sts = STS_IGNORED;
               end
            end
         end
         S_SCAN: begin
            w_in.pv = 1'b0;
            if (issue_left && !scan_stop) begin
               ram_re = 1'b1;
               w_in.iss = w_ff.iss + CW'(1);
               w_in.pv = 1'b1;
               w_in.pidx = w_ff.iss[IW-1:0];
               w_in.pfresh = fresh_ff[w_ff.pool] && (w_ff.iss == '0);
            end
            if (w_ff.pv && !scan_stop) begin
               if (w_ff.op == OP_RELEASE) begin
                  if (SW'(ent_start) == hi_req) begin
                     w_in.r_ok = 1'b1;
                     w_in.r_idx = w_ff.pidx;
                     w_in.r_end = ent_end;
                  end
                  if (ent_end == SW'(w_ff.off)) begin
                     w_in.l_ok = 1'b1;
                     w_in.l_idx = w_ff.pidx;
                     w_in.l_start = ent_start;
                  end
               end else if (ent_len >= w_ff.size
                            && (!w_ff.best_ok || ent_len - w_ff.size < w_ff.best_rem)) begin
                  w_in.best_ok = 1'b1;
                  w_in.best_idx = w_ff.pidx;
                  w_in.best_rem = ent_len - w_ff.size;
                  w_in.best_len = ent_len;
                  w_in.best_start = ent_start;
               end
            end
            if (scan_done) begin
               w_in.iss = '0;
               w_in.pv = 1'b0;
               w_in.k = '0;
               if (w_ff.op == OP_RELEASE) begin
                  w_in.r_ok = eff_r;
                  if (!go_compact) begin
                     w_in.sts = STS_FULL;
                  end
                  w_in.app_en = 1'b1;
                  w_in.app_start = lo_m[ADDR_BITS-1:0];
                  w_in.app_len = (diff_m > SW'(LEN_MAX)) ? LEN_MAX : diff_m[LEN_W-1:0];
               end else if (!w_ff.best_ok) begin
                  w_in.sts = STS_NO_FIT;
               end else if (w_ff.op == OP_ALLOC) begin
                  w_in.goff = w_ff.best_start;
                  w_in.glen = w_ff.best_len;
                  w_in.app_en = (ns < best_end) && (ns < (SW'(1) << ADDR_BITS));
                  w_in.app_start = ns[ADDR_BITS-1:0];
                  w_in.app_len = LEN_W'(best_end - ns);
               end
            end
         end
         S_COMPACT: begin
            w_in.pv = 1'b0;
            if (issue_left) begin
               ram_re = 1'b1;
               w_in.iss = w_ff.iss + CW'(1);
               w_in.pv = 1'b1;
               w_in.pidx = w_ff.iss[IW-1:0];
               w_in.pfresh = fresh_ff[w_ff.pool] && (w_ff.iss == '0);
            end
            // shift surviving entries down over the removed ones
            if (w_ff.pv && !pidx_removed) begin
               ram_we = 1'b1;
               w_in.k = w_ff.k + CW'(1);
               if (w_ff.k == '0) begin
                  fresh_in[w_ff.pool] = 1'b0;
               end
            end
         end
         S_APPEND: begin
            count_in[w_ff.pool] = w_ff.k;
            if (w_ff.app_en) begin
               ram_we = 1'b1;
               ram_wdata = {w_ff.app_start, w_ff.app_len};
               count_in[w_ff.pool] = w_ff.k + CW'(1);
               if (w_ff.k == '0) begin
                  fresh_in[w_ff.pool] = 1'b0;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = w_ff.sts;
               rsp_goff_in = w_ff.goff;
               rsp_glen_in = w_ff.glen;
            end
         end
         default: ;
      endcase

      if (csr_wr) begin
         if (reg_type'(csr_idx) == REG_ALIGN) begin
            align_in = csr_pwdata[3:0];
         end
         for (int p = 0; p < CFG_POOLS; p++) begin
            if (32'(csr_idx) == 32'(REG_CAP0) + p) begin
               cap_in[p] = csr_pwdata[LEN_W-1:0];
               count_in[p] = CW'(1);
               fresh_in[p] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_type'(csr_idx) == REG_ALIGN) begin
         csr_prdata = CSR_DW'(align_ff);
      end
      for (int p = 0; p < CFG_POOLS; p++) begin
         if (32'(csr_idx) == 32'(REG_CAP0) + p) begin
            csr_prdata = CSR_DW'(cap_ff[p]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         w_ff <= '0;
         align_ff <= ALIGN_RESET;
         fresh_ff <= '1;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < POOLS; p++) begin
            cap_ff[p] <= CAP_RESET;
            count_ff[p] <= CW'(1);
         end
      end else begin
         state_ff <= state_in;
         w_ff <= w_in;
         align_ff <= align_in;
         fresh_ff <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff <= cap_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_goff_ff <= rsp_goff_in;
      rsp_glen_ff <= rsp_glen_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.grant_offset = rsp_goff_ff;
   assign rsp_ch.grant_length = rsp_glen_ff;

   bfa_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("accepted item left the block idle");

   a_compact_behind_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMPACT && ram_we) |-> w_ff.k <= CW'(w_ff.pidx))
      else $error("compaction write overtook its read");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPEND && w_ff.app_en) |-> w_ff.k < CW'(FREE_ENTRIES))
      else $error("append past end of free list");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside done state");
endmodule
